// ===== design/sma_pkg.sv =====
// Shared constants and types for the moving-average filter.
package sma_pkg;

    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int           WIN_W        = 7;
    localparam logic [6:0]   WINDOW_RESET = 7'd10;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/sma_store.sv =====
// Sample ring memory: one write port, one registered read port.
module sma_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sma_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module sma_div import sma_pkg::*; #(
    parameter int DIVIDEND_W = 31,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output div_stat_t             stat
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] shreg_reg, shreg_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_comb begin
        trial      = {rem_reg, shreg_reg[DIVIDEND_W-1]};
        fits       = (trial >= {1'b0, div_reg});
        rem_next   = fits ? DIVISOR_W'(trial - {1'b0, div_reg}) : trial[DIVISOR_W-1:0];
        shreg_next = {shreg_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shreg_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end else if (busy_reg) begin
            shreg_reg <= shreg_next;
            rem_reg   <= rem_next;
        end
    end

    assign quotient  = shreg_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/simple_moving_average_filter_top.sv =====
// Top level of the boxcar moving-average filter for signed speed samples.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser = cmd, s_tdata = speed_sample
//  m_       out  m_tvalid/m_tready  m_tdata = average_speed
//  cfg_     in   cfg_wr_en          cfg_wr_data = window_length
//
// A tick is answered from the idle state. A sample passes through ST_SUB (only once
// the store is full), ST_ADD, ST_START and ST_WAIT; the wait in ST_WAIT on the
// bit-serial divider of sum by count is the longest step.
// Reset is synchronous: window 10, store empty, no average yet; the ring memory
// itself is not cleared, only entries written since the last clear are read.
// A tick that finds the output register still full waits for m_tready.
module simple_moving_average_filter_top import sma_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // [SW-1:0] speed_sample
    input  logic                                   s_tuser,  // [0] cmd
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // [SW-1:0] average_speed
    input  logic                                   cfg_wr_en,
    input  logic [WIN_W-1:0]                       cfg_wr_data
);

    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int EW     = (WIN_W > CNT_W) ? WIN_W : CNT_W;
    localparam int IW     = CNT_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUB   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [WIN_W-1:0]               win_reg, win_next;
    logic [PTR_W-1:0]               wp_reg, wp_next;
    logic [CNT_W-1:0]               held_reg, held_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic [SAMPLE_WIDTH-1:0]        latest_reg, latest_next;
    logic                           have_reg, have_next;
    logic                           ovalid_reg, ovalid_next;
    logic [SAMPLE_WIDTH-1:0]        odata_reg, odata_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;

    logic                    accept;
    logic                    slot_free;
    logic [EW-1:0]           win_x;
    logic [EW-1:0]           w_eff;
    logic                    full;
    logic [IW-1:0]           wp_x, held_x, oldest_x;
    logic                    rd_en;
    logic signed [SAMPLE_WIDTH-1:0] rd_data;
    logic                    store_wr;
    logic                    div_start;
    logic [SUM_W-1:0]        sum_mag;
    logic [SUM_W-1:0]        quotient;
    logic [SUM_W-1:0]        q_neg;
    div_stat_t               div_stat;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign slot_free = !ovalid_reg || m_tready;

    // window of zero acts as one, anything above the store depth saturates
    always_comb begin
        win_x = EW'(win_reg);
        if (win_x == '0) begin
            w_eff = EW'(1);
        end else if (win_x > EW'(MAX_WINDOW)) begin
            w_eff = EW'(MAX_WINDOW);
        end else begin
            w_eff = win_x;
        end
    end

    assign full = (EW'(held_reg) >= w_eff);

    // oldest entry sits held_count places behind the write pointer
    always_comb begin
        wp_x   = IW'(wp_reg);
        held_x = IW'(held_reg);
        if (wp_x >= held_x) begin
            oldest_x = wp_x - held_x;
        end else begin
            oldest_x = wp_x + IW'(MAX_WINDOW) - held_x;
        end
    end

    assign rd_en     = accept && (s_tuser == CMD_SAMPLE) && full;
    assign store_wr  = (state_reg == ST_ADD);
    assign div_start = (state_reg == ST_START);
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign q_neg     = ~quotient + SUM_W'(1);

    sma_store #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (rd_en),
        .rd_addr (oldest_x[PTR_W-1:0]),
        .rd_data (rd_data)
    );

    sma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (held_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb begin
        state_next  = state_reg;
        win_next    = win_reg;
        wp_next     = wp_reg;
        held_next   = held_reg;
        sum_next    = sum_reg;
        latest_next = latest_reg;
        have_next   = have_reg;
        sample_next = sample_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_TICK) begin
                        if (have_reg) begin
                            if (slot_free) begin
                                ovalid_next = 1'b1;
                                odata_next  = latest_reg;
                            end else begin
                                state_next = ST_EMIT;
                            end
                        end
                    end else begin
                        sample_next = s_tdata[SAMPLE_WIDTH-1:0];
                        state_next  = full ? ST_SUB : ST_ADD;
                    end
                end
            end
            ST_SUB: begin
                sum_next   = sum_reg - SUM_W'(rd_data);
                held_next  = held_reg - CNT_W'(1);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                sum_next   = sum_reg + SUM_W'(sample_reg);
                held_next  = held_reg + CNT_W'(1);
                wp_next    = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + PTR_W'(1);
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    latest_next = sum_reg[SUM_W-1] ? q_neg[SAMPLE_WIDTH-1:0]
                                                   : quotient[SAMPLE_WIDTH-1:0];
                    have_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = latest_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a window write empties the store but keeps the last average
        if (cfg_wr_en) begin
            win_next  = cfg_wr_data;
            wp_next   = '0;
            held_next = '0;
            sum_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            win_reg    <= WINDOW_RESET;
            wp_reg     <= '0;
            held_reg   <= '0;
            sum_reg    <= '0;
            latest_reg <= '0;
            have_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            win_reg    <= win_next;
            wp_reg     <= wp_next;
            held_reg   <= held_next;
            sum_reg    <= sum_next;
            latest_reg <= latest_next;
            have_reg   <= have_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        odata_reg  <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = DATA_W'(odata_reg);

    a_held_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (EW'(held_reg) <= w_eff))
        else $error("held count exceeds window");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside wait state");

    a_sample_sets_have: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) && div_stat.done |=> have_reg && (state_reg == ST_IDLE))
        else $error("average not taken after divide");

    a_div_idle_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("input beat taken while divider busy");

    a_no_output_from_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) && !$past(ovalid_reg) |-> !ovalid_reg)
        else $error("sample produced an output beat");

endmodule

// ===== dv/simple_moving_average_filter_top_tb.sv =====
// Testbench for the moving-average filter: directed, random and backpressure tests.
`timescale 1ns / 1ps

module simple_moving_average_filter_top_tb;
    import sma_pkg::*;

    localparam int SW      = SAMPLE_WIDTH_DEF;
    localparam int DEPTH   = MAX_WINDOW_DEF;
    localparam int TDATA_W = ((SW + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               s_tuser = CMD_SAMPLE;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               cfg_wr_en = 1'b0;
    logic [WIN_W-1:0]   cfg_wr_data = '0;

    // filter model state
    logic signed [SW-1:0] ring_mem [DEPTH];
    int                   ring_wp;
    int                   ring_count;
    longint               win_sum;
    logic signed [SW-1:0] cur_avg;
    bit                   avg_valid;
    logic [WIN_W-1:0]     win_len;

    logic signed [SW-1:0] exp_avg_q [$];
    int                   err_cnt = 0;
    int                   cycle_cnt = 0;
    bit                   idle_en = 1'b0;
    int                   rx_hold_cycles = 0;

    simple_moving_average_filter_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever begin
            #1 aclk = ~aclk;
        end
    end

    function automatic int eff_window(input logic [WIN_W-1:0] w);
        if (w == 0)
            return 1;
        if (int'(w) > DEPTH)
            return DEPTH;
        return int'(w);
    endfunction

    function automatic void clear_ring();
        ring_wp    = 0;
        ring_count = 0;
        win_sum    = 0;
    endfunction

    function automatic void filter_update(input logic cmd, input logic [SW-1:0] raw);
        int oldest;
        if (cmd == CMD_SAMPLE) begin
            if (ring_count >= eff_window(win_len)) begin
                oldest  = (ring_wp + DEPTH - ring_count) % DEPTH;
                win_sum = win_sum - ring_mem[oldest];
                ring_count--;
            end
            ring_mem[ring_wp] = $signed(raw);
            win_sum = win_sum + $signed(raw);
            ring_count++;
            ring_wp   = (ring_wp + 1) % DEPTH;
            // signed divide truncates toward zero
            cur_avg   = SW'(win_sum / longint'(ring_count));
            avg_valid = 1'b1;
        end else if (avg_valid) begin
            exp_avg_q.insert(exp_avg_q.size(), cur_avg);
        end
    endfunction

    // model update and result check on every rising edge
    always @(posedge aclk) begin
        logic signed [SW-1:0] want;
        if (!aresetn) begin
            clear_ring();
            cur_avg   = '0;
            avg_valid = 1'b0;
            win_len   = WINDOW_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (exp_avg_q.size() == 0) begin
                    $error("average_speed: unexpected beat, got %0d", $signed(m_tdata[SW-1:0]));
                    err_cnt++;
                end else begin
                    want = exp_avg_q[0];
                    exp_avg_q.delete(0);
                    if (m_tdata[SW-1:0] !== want) begin
                        $error("average_speed: expected %0d, got %0d",
                               want, $signed(m_tdata[SW-1:0]));
                        err_cnt++;
                    end
                end
            end
            if (cfg_wr_en) begin
                win_len = cfg_wr_data;
                clear_ring();
            end
            if (s_tvalid && s_tready)
                filter_update(s_tuser, s_tdata[SW-1:0]);
        end
    end

    // output side: random stalls plus the long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // called just after a rising edge; returns just after the beat is taken
    task automatic send_beat(input logic cmd, input logic [SW-1:0] smp);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= TDATA_W'(smp);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (exp_avg_q.size() != 0) @(posedge aclk);
        // a sample in flight gives no result, so allow its full latency
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SW'($signed($urandom_range(0, 15)) - 8);
            default: return SW'($urandom());
        endcase
    endfunction

    task automatic run_random(input int n);
        int burst;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat(CMD_TICK, SW'($urandom()));
            end else if ($urandom_range(0, 15) == 0) begin
                // long run of samples to push past the window
                burst = $urandom_range(8, 80);
                for (int k = 0; k < burst && i < n; k++, i++)
                    send_beat(CMD_SAMPLE, rand_sample());
            end else begin
                send_beat(CMD_SAMPLE, rand_sample());
            end
        end
    endtask

    task automatic test_directed();
        idle_en = 1'b0;
        send_beat(CMD_TICK, SAMPLE_MAX);           // no average yet: no result
        send_beat(CMD_SAMPLE, SAMPLE_MAX);
        send_beat(CMD_TICK, '0);
        send_beat(CMD_SAMPLE, SAMPLE_MIN);
        send_beat(CMD_TICK, '0);
        send_beat(CMD_SAMPLE, '1);
        send_beat(CMD_TICK, '0);
        write_window(7'd1);
        send_beat(CMD_TICK, '0);                   // average survives the clear
        send_beat(CMD_SAMPLE, SW'(5));
        send_beat(CMD_SAMPLE, SW'(-3));
        send_beat(CMD_TICK, '0);
        write_window(7'd0);                        // behaves as a window of one
        send_beat(CMD_SAMPLE, SW'(100));
        send_beat(CMD_SAMPLE, SW'(-100));
        send_beat(CMD_TICK, '0);
        write_window(7'd2);
        send_beat(CMD_SAMPLE, SW'(-3));
        send_beat(CMD_SAMPLE, '0);
        send_beat(CMD_TICK, '0);                   // -1.5 truncates to -1
        write_window(7'd127);                      // saturates to store depth
        send_beat(CMD_SAMPLE, SW'(1));
        send_beat(CMD_SAMPLE, SW'(2));
        send_beat(CMD_TICK, '1);
    endtask

    task automatic test_random_windows();
        logic [WIN_W-1:0] w;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       w = 7'd64;
                1:       w = 7'd127;
                2:       w = 7'd1;
                3:       w = 7'd0;
                4:       w = WINDOW_RESET;
                5:       w = 7'd65;
                default: w = WIN_W'($urandom_range(0, 127));
            endcase
            write_window(w);
            idle_en = (p != 6);
            run_random(225);
        end
    endtask

    task automatic test_output_backpressure();
        idle_en = 1'b0;
        write_window(7'd4);
        for (int i = 0; i < 6; i++)
            send_beat(CMD_SAMPLE, rand_sample());
        rx_hold_cycles = 300;
        // ticks pile up behind the held output register
        for (int i = 0; i < 30; i++)
            send_beat((i % 5 == 4) ? CMD_SAMPLE : CMD_TICK, rand_sample());
    endtask

    task automatic test_no_idle();
        write_window(WIN_W'($urandom_range(1, 64)));
        idle_en = 1'b0;
        run_random(200);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_windows();
        test_output_backpressure();
        test_no_idle();
        wait_drained();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
